@@ hdl/cdh_pkg.sv @@
// ----------------------------------------------------------------------------
// cdh_pkg
// Shared types, constants and helpers of the coefficient decompose/hint unit.
// ----------------------------------------------------------------------------
package cdh_pkg;

  localparam logic [11:0] Q          = 12'd3109;
  localparam logic [12:0] Q_X2       = 13'd6218;
  localparam logic [8:0]  ALPHA      = 9'd259;
  localparam logic [8:0]  HALF_ALPHA = 9'd129;
  localparam logic [4:0]  N_IDX      = 5'd12;
  localparam logic [4:0]  N_IDX_M1   = 5'd11;
  // floor(2^16 / 259): quotient estimate is short by at most one
  localparam logic [7:0]  RECIP      = 8'd253;

  typedef enum logic [1:0] {
    OP_HIGH      = 2'd0,
    OP_LOW       = 2'd1,
    OP_MAKE_HINT = 2'd2,
    OP_USE_HINT  = 2'd3
  } cdh_op_e;

  typedef struct packed {
    cdh_op_e    op;
    logic       hint;
    logic       pos;
  } cdh_ctrl_t;

  // reduce a value below 3 * Q into [0, Q)
  function automatic logic [11:0] mod_q13(input logic [12:0] v);
    logic [12:0] r;
    if (v >= Q_X2) begin
      r = v - Q_X2;
    end else if (v >= {1'b0, Q}) begin
      r = v - {1'b0, Q};
    end else begin
      r = v;
    end
    return r[11:0];
  endfunction

endpackage

@@ hdl/cdh_result.sv @@
// ----------------------------------------------------------------------------
// cdh_result
// Final result select: scaled high part, low part, hint bit or hinted high part.
// ----------------------------------------------------------------------------
module cdh_result
  import cdh_pkg::*;
(
  input  cdh_ctrl_t   ctrl_i,
  input  logic [11:0] coeff_i,
  input  logic [4:0]  idx_x_i,
  input  logic [4:0]  idx_d_i,
  output logic [11:0] result_o
);

  // (idx * 259) mod 3109 with index 12 wrapped to 0
  function automatic logic [11:0] high_of_idx(input logic [4:0] idx);
    logic [11:0] v;
    case (idx)
      5'd0:    v = 12'd0;
      5'd1:    v = 12'd259;
      5'd2:    v = 12'd518;
      5'd3:    v = 12'd777;
      5'd4:    v = 12'd1036;
      5'd5:    v = 12'd1295;
      5'd6:    v = 12'd1554;
      5'd7:    v = 12'd1813;
      5'd8:    v = 12'd2072;
      5'd9:    v = 12'd2331;
      5'd10:   v = 12'd2590;
      5'd11:   v = 12'd2849;
      5'd12:   v = 12'd0;
      5'd13:   v = 12'd258;
      5'd14:   v = 12'd517;
      5'd15:   v = 12'd776;
      5'd16:   v = 12'd1035;
      default: v = 12'd0;
    endcase
    return v;
  endfunction

  logic [11:0] hp_x;
  logic [11:0] hp_d;
  logic [4:0]  step_n;
  logic [4:0]  step_m;
  logic [11:0] step_val;

  assign hp_x = high_of_idx(idx_x_i);
  assign hp_d = high_of_idx(idx_d_i);

  // step the unwrapped index up or down by one, modulo 12
  assign step_n = ctrl_i.pos ? idx_x_i + 5'd1 : idx_x_i + N_IDX_M1;

  always_comb begin
    if (step_n >= (N_IDX << 1)) begin
      step_m = step_n - (N_IDX << 1);
    end else if (step_n >= N_IDX) begin
      step_m = step_n - N_IDX;
    end else begin
      step_m = step_n;
    end
  end

  assign step_val = high_of_idx(step_m);

  always_comb begin
    unique case (ctrl_i.op)
      OP_HIGH:      result_o = hp_x;
      OP_LOW:       result_o = mod_q13({1'b0, coeff_i} + {1'b0, Q} - {1'b0, hp_x});
      OP_MAKE_HINT: result_o = {11'd0, hp_x != hp_d};
      OP_USE_HINT:  result_o = ctrl_i.hint ? step_val : hp_x;
      default:      result_o = hp_x;
    endcase
  end

endmodule

@@ hdl/coeff_decompose_hint_unit.sv @@
// ----------------------------------------------------------------------------
// coeff_decompose_hint_unit
// Pipelined per-coefficient decompose, make-hint and use-hint unit mod 3109.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis_*: one coefficient operation per transfer. tuser
//   carries the op code, tdata carries coeff, second_coeff and hint_bit.
//   Output stream m_axis_*: one result per input, in input order.
//   Throughput: one item per cycle while the receiver does not stall, set by
//   the six-stage pipeline; the divide by 259 is a reciprocal multiply plus
//   one correction step, done once for coeff and once for the make-hint
//   difference.
//   Each stage advances when it is empty or the stage after it advances, so
//   bubbles are squeezed out and s_axis_tready_o stays high while any stage
//   is free, also while a finished result waits at the output.
//   When the receiver stalls the pipeline fills and then holds; no item is
//   dropped or repeated.
//   Reset empties every stage, so the block can take an item as soon as
//   rst_ni is released.
// ----------------------------------------------------------------------------
module coeff_decompose_hint_unit
  import cdh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // coeff[11:0], second_coeff[23:12], hint_bit[24]
  input  logic [1:0]  s_axis_tuser_i,   // op[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // result[11:0]
);

  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic en1, en2, en3, en4, en5, en6;

  assign en6 = !v6_q || m_axis_tready_i;
  assign en5 = !v5_q || en6;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign s_axis_tready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
      if (en6) v6_q <= v5_q;
    end
  end

  // stage 1: input register
  cdh_op_e     op1_q;
  logic [11:0] x1_q, c1_q;
  logic        h1_q;

  // stage 2: difference and reciprocal product of x
  cdh_op_e     op2_q;
  logic [11:0] x2_q;
  logic        h2_q;
  logic [12:0] t2_q;
  logic [19:0] px2_q;
  logic [11:0] c2r;

  assign c2r = (c1_q >= Q) ? c1_q - Q : c1_q;

  // stage 3: raw remainder of x, reduced difference
  cdh_op_e     op3_q;
  logic [11:0] x3_q;
  logic        h3_q;
  logic [3:0]  qx3_q;
  logic [9:0]  rx3_q;
  logic [11:0] diff3_q;
  logic [3:0]  qx2;
  logic [11:0] qx2_mul;

  assign qx2     = px2_q[19:16];
  assign qx2_mul = 12'(16'(qx2) * 16'(ALPHA));

  // stage 4: corrected split of x, reciprocal product of difference
  cdh_op_e     op4_q;
  logic [11:0] x4_q;
  logic        h4_q;
  logic [3:0]  qx4_q;
  logic [8:0]  remx4_q;
  logic [11:0] diff4_q;
  logic [19:0] pd4_q;

  // stage 5: index of x, raw remainder of difference
  cdh_op_e     op5_q;
  logic [11:0] x5_q;
  logic        h5_q;
  logic [4:0]  idx_x5_q;
  logic        pos_x5_q;
  logic [3:0]  qd5_q;
  logic [9:0]  rd5_q;
  logic [4:0]  idx_x4;
  logic [3:0]  qd4;
  logic [11:0] qd4_mul;

  assign idx_x4  = (remx4_q > HALF_ALPHA) ? {1'b0, qx4_q} + 5'd1 : {1'b0, qx4_q};
  assign qd4     = pd4_q[19:16];
  assign qd4_mul = 12'(16'(qd4) * 16'(ALPHA));

  // stage 6: index of difference and result select
  cdh_op_e     op6_q;
  logic [11:0] res6_q;
  logic [3:0]  qd5c;
  logic [8:0]  rd5c;
  logic [4:0]  idx_d5;
  cdh_ctrl_t   ctrl5;
  logic [11:0] res5;

  always_comb begin
    if (rd5_q >= {1'b0, ALPHA}) begin
      qd5c = qd5_q + 4'd1;
      rd5c = 9'(rd5_q - {1'b0, ALPHA});
    end else begin
      qd5c = qd5_q;
      rd5c = rd5_q[8:0];
    end
  end

  assign idx_d5 = (rd5c > HALF_ALPHA) ? {1'b0, qd5c} + 5'd1 : {1'b0, qd5c};

  assign ctrl5 = '{op: op5_q, hint: h5_q, pos: pos_x5_q};

  cdh_result u_result (
    .ctrl_i   (ctrl5),
    .coeff_i  (x5_q),
    .idx_x_i  (idx_x5_q),
    .idx_d_i  (idx_d5),
    .result_o (res5)
  );

  always_ff @(posedge clk_i) begin
    if (en1) begin
      op1_q <= cdh_op_e'(s_axis_tuser_i[1:0]);
      x1_q  <= s_axis_tdata_i[11:0];
      c1_q  <= s_axis_tdata_i[23:12];
      h1_q  <= s_axis_tdata_i[24];
    end
    if (en2) begin
      op2_q <= op1_q;
      x2_q  <= x1_q;
      h2_q  <= h1_q;
      t2_q  <= {1'b0, x1_q} + {1'b0, Q} - {1'b0, c2r};
      px2_q <= 20'(x1_q) * 20'(RECIP);
    end
    if (en3) begin
      op3_q   <= op2_q;
      x3_q    <= x2_q;
      h3_q    <= h2_q;
      qx3_q   <= qx2;
      rx3_q   <= 10'(x2_q - qx2_mul);
      diff3_q <= mod_q13(t2_q);
    end
    if (en4) begin
      op4_q   <= op3_q;
      x4_q    <= x3_q;
      h4_q    <= h3_q;
      diff4_q <= diff3_q;
      pd4_q   <= 20'(diff3_q) * 20'(RECIP);
      // fix the quotient estimate when it came out one short
      if (rx3_q >= {1'b0, ALPHA}) begin
        qx4_q   <= qx3_q + 4'd1;
        remx4_q <= 9'(rx3_q - {1'b0, ALPHA});
      end else begin
        qx4_q   <= qx3_q;
        remx4_q <= rx3_q[8:0];
      end
    end
    if (en5) begin
      op5_q    <= op4_q;
      x5_q     <= x4_q;
      h5_q     <= h4_q;
      idx_x5_q <= idx_x4;
      pos_x5_q <= (remx4_q <= HALF_ALPHA) && (remx4_q != 9'd0);
      qd5_q    <= qd4;
      rd5_q    <= 10'(diff4_q - qd4_mul);
    end
    if (en6) begin
      op6_q  <= op5_q;
      res6_q <= res5;
    end
  end

  assign m_axis_tvalid_o = v6_q;
  assign m_axis_tdata_o  = {4'd0, res6_q};

`ifndef NO_ASSERTIONS
  a_ready_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v1_q |-> s_axis_tready_o)
    else $error("input not ready while first stage is empty");

  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (res6_q < Q))
    else $error("result not reduced below modulus");

  a_hint_is_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && op6_q == OP_MAKE_HINT) |-> (res6_q <= 12'd1))
    else $error("make-hint result is not a single bit");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v5_q |-> (idx_x5_q <= 5'd16))
    else $error("high index out of range");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v5_q && !en6) |=> (v5_q && $stable(res5)))
    else $error("stalled stage lost its item");
`endif

endmodule

@@ verif/tb_coeff_decompose_hint_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_coeff_decompose_hint_unit
// Self-checking bench for the decompose / make-hint / use-hint unit. A
// directed set hits the index wrap, the centred-remainder edges and
// out-of-range coefficients, then random items biased toward the 259-step
// boundaries follow. Both stream sides idle at random. Every result is
// compared in order against an in-bench prediction.
// ----------------------------------------------------------------------------
import cdh_pkg::*;

class decompose_checker;
  logic [11:0] expected_results[$];
  int          errors;

  function new();
    errors = 0;
  endfunction

  // centred split of x by 259: returns the unwrapped index, pos = r0 > 0
  function int unsigned split_index(int unsigned x, output bit pos);
    int unsigned rem;
    rem = x % ALPHA;
    if (rem > HALF_ALPHA) begin
      pos = 1'b0;
      return (x + ALPHA - rem) / ALPHA;
    end
    pos = (rem != 0);
    return (x - rem) / ALPHA;
  endfunction

  function int unsigned scaled_high(int unsigned x);
    bit          pos;
    int unsigned idx;
    idx = split_index(x, pos);
    if (idx == N_IDX) begin
      idx = 0;
    end
    return (idx * ALPHA) % Q;
  endfunction

  function logic [11:0] predict_result(cdh_op_e op, logic [11:0] x, logic [11:0] c2,
                                       logic h);
    int unsigned r;
    int unsigned diff;
    int unsigned idx;
    bit          pos;
    case (op)
      OP_HIGH: begin
        r = scaled_high(x);
      end
      OP_LOW: begin
        r = (x + Q - scaled_high(x)) % Q;
      end
      OP_MAKE_HINT: begin
        diff = (x + Q - (c2 % Q)) % Q;
        r = (scaled_high(x) != scaled_high(diff)) ? 1 : 0;
      end
      default: begin
        if (!h) begin
          r = scaled_high(x);
        end else begin
          // step the unwrapped index toward the side r0 leans to
          idx = split_index(x, pos);
          if (pos) begin
            r = ((idx + 1) % N_IDX) * ALPHA;
          end else begin
            r = ((idx + N_IDX_M1) % N_IDX) * ALPHA;
          end
        end
      end
    endcase
    return r[11:0];
  endfunction

  function void note_item(cdh_op_e op, logic [11:0] x, logic [11:0] c2, logic h);
    expected_results.push_back(predict_result(op, x, c2, h));
  endfunction

  function void check_result(logic [15:0] tdata);
    logic [11:0] exp_val;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result, actual %0d", $time, tdata[11:0]);
      errors++;
      return;
    end
    exp_val = expected_results.pop_front();
    if (tdata[11:0] !== exp_val) begin
      $display("%0t: result mismatch, expected %0d, actual %0d",
               $time, exp_val, tdata[11:0]);
      errors++;
    end
  endfunction

  function int pending();
    return expected_results.size();
  endfunction
endclass

module tb_coeff_decompose_hint_unit;
  localparam int NUM_RANDOM  = 2000;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_WAIT  = 12;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [31:0] s_tdata  = '0;
  logic [1:0]  s_tuser  = '0;
  logic        m_tready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [15:0] m_axis_tdata_o;

  int          cycle_count = 0;
  int          tx_count    = 0;
  int          rx_count    = 0;

  decompose_checker sb;

  coeff_decompose_hint_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // every third stretch of 64 items runs with no idling
  function automatic int draw_wait(int count);
    if ((count / 64) % 3 == 2) begin
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  // monitors: values read here are the ones present before the edge
  always @(posedge clk_i) begin
    if (rst_ni && s_tvalid && s_axis_tready_o) begin
      sb.note_item(cdh_op_e'(s_tuser), s_tdata[11:0], s_tdata[23:12], s_tdata[24]);
    end
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      sb.check_result(m_axis_tdata_o);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_coeff_decompose_hint_unit NOT OK");
      $finish;
    end
  end

  // receiver: stall a random number of cycles before each transfer
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = draw_wait(rx_count + 32);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      rx_count++;
    end
  end

  task automatic send_item(cdh_op_e op, logic [11:0] x, logic [11:0] c2, logic h);
    int gap;
    gap = draw_wait(tx_count);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {7'b0, h, c2, x};
    do @(posedge clk_i); while (!s_axis_tready_o);
    tx_count++;
  endtask

  // hold the input idle until every expected result is back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic send_random_item();
    cdh_op_e     op;
    logic [11:0] x;
    logic [11:0] c2;
    int          k;
    op = cdh_op_e'($urandom_range(0, 3));
    k  = $urandom_range(0, 15);
    case ($urandom_range(0, 9))
      0: x = 12'($urandom_range(3109, 4095));
      1, 2: x = 12'(k * 259 + ($urandom_range(0, 1) ? 129 : 130) + $urandom_range(0, 2) - 1);
      3: x = 12'(k * 259 + 259 + $urandom_range(0, 2) - 1);
      4: x = 12'($urandom_range(0, 4095));
      default: x = 12'($urandom_range(0, 3108));
    endcase
    case ($urandom_range(0, 7))
      0, 1, 2: c2 = 12'($urandom_range(0, 3108));
      3, 4, 5: c2 = 12'((3109 + $urandom_range(0, 520) - 260) % 3109);
      default: c2 = 12'($urandom_range(0, 4095));
    endcase
    send_item(op, x, c2, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // high part: centred edges, index wrap, out-of-range values
    send_item(OP_HIGH, 12'd0, 12'd0, 1'b0);
    send_item(OP_HIGH, 12'd129, 12'd4095, 1'b1);
    send_item(OP_HIGH, 12'd130, 12'd0, 1'b0);
    send_item(OP_HIGH, 12'd2978, 12'd0, 1'b1);
    send_item(OP_HIGH, 12'd2979, 12'd0, 1'b0);
    send_item(OP_HIGH, 12'd3108, 12'd0, 1'b0);
    send_item(OP_HIGH, 12'd4095, 12'd0, 1'b1);
    // low part
    send_item(OP_LOW, 12'd0, 12'd0, 1'b0);
    send_item(OP_LOW, 12'd130, 12'd0, 1'b1);
    send_item(OP_LOW, 12'd2979, 12'd0, 1'b0);
    send_item(OP_LOW, 12'd3108, 12'd4095, 1'b0);
    send_item(OP_LOW, 12'd4095, 12'd0, 1'b1);
    // make hint: oversized ct0, crossing a boundary, wrap through zero
    send_item(OP_MAKE_HINT, 12'd0, 12'd0, 1'b0);
    send_item(OP_MAKE_HINT, 12'd0, 12'd4095, 1'b1);
    send_item(OP_MAKE_HINT, 12'd130, 12'd1, 1'b0);
    send_item(OP_MAKE_HINT, 12'd3108, 12'd3108, 1'b1);
    send_item(OP_MAKE_HINT, 12'd1, 12'd2, 1'b0);
    // use hint: both directions, unwrapped index of 12 and above
    send_item(OP_USE_HINT, 12'd500, 12'd0, 1'b0);
    send_item(OP_USE_HINT, 12'd129, 12'd0, 1'b1);
    send_item(OP_USE_HINT, 12'd0, 12'd0, 1'b1);
    send_item(OP_USE_HINT, 12'd130, 12'd0, 1'b1);
    send_item(OP_USE_HINT, 12'd2979, 12'd0, 1'b1);
    send_item(OP_USE_HINT, 12'd3108, 12'd0, 1'b1);
    send_item(OP_USE_HINT, 12'd4095, 12'd0, 1'b1);
    drain_results();

    for (int i = 0; i < NUM_RANDOM; i++) begin
      send_random_item();
      if (i == NUM_RANDOM / 2) begin
        drain_results();
      end
    end
    drain_results();
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_coeff_decompose_hint_unit OK");
    end else begin
      $display("tb_coeff_decompose_hint_unit NOT OK");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
hdl/cdh_pkg.sv
hdl/cdh_result.sv
hdl/coeff_decompose_hint_unit.sv
verif/tb_coeff_decompose_hint_unit.sv
